>>> rtl/core/crc8_frame_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// CRC-8 frame encoder assertion macros
// Shared property forms for the checkers of the frame encoder.
// ----------------------------------------------------------------------------
`ifndef CRC8_FRAME_ENCODER_TOP_DEFINES_SVH
`define CRC8_FRAME_ENCODER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRC8FE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRC8FE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/crc8fe_pkg.sv
// ----------------------------------------------------------------------------
// CRC-8 frame encoder package
// Payload types, queue entry type, register indexes and the CRC-8 step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc8fe_pkg;

    localparam int DATA_W    = 8;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] CRC_POLY = 8'h07;
    localparam logic [DATA_W-1:0] CRC_TOP  = 8'h80;
    localparam logic [DATA_W-1:0] CRC_INIT = 8'h00;

    localparam logic [DATA_W-1:0] HEADER_FIRST_RESET  = 8'hAA;
    localparam logic [DATA_W-1:0] HEADER_SECOND_RESET = 8'h55;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;

    // One input transaction.
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic [DATA_W-1:0] frame_type;
        logic [LEN_W-1:0]  payload_len;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              frame_end;
    } out_item_t;

    // Classified payload byte passed from the front end to the back end.
    typedef struct packed {
        logic              first;
        logic              last;
        logic [DATA_W-1:0] len_byte;
        logic [DATA_W-1:0] frame_type;
        logic [DATA_W-1:0] data_byte;
    } entry_t;

    // Feed one byte into a CRC-8 (MSB first, no reflection, no final xor).
    function automatic logic [DATA_W-1:0] crc_feed(input logic [DATA_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < DATA_W; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/crc8fe_front.sv
// ----------------------------------------------------------------------------
// CRC-8 frame encoder front end
// Accepts payload bytes, tracks the frame position and classifies each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc8fe_front #(
    parameter int MAX_PAYLOAD = 27
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  crc8fe_pkg::in_item_t in_item,
    input  logic                 q_full,
    output logic                 q_push,
    output crc8fe_pkg::entry_t   q_entry
);
    import crc8fe_pkg::*;

    logic [LEN_W-1:0] bytes_seen_reg;
    logic [LEN_W-1:0] bytes_seen_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] count_inc;
    logic             first;
    logic             last;

    assign q_push = push && !q_full;
    assign first  = (bytes_seen_reg == '0);

    // Effective length: latched at the first byte, clamped to 1..MAX_PAYLOAD.
    always_comb
    begin
        if (first) begin
            len_eff = in_item.payload_len;
            if (len_eff == '0) begin
                len_eff = LEN_W'(1);
            end
            if (int'(len_eff) > MAX_PAYLOAD) begin
                len_eff = LEN_W'(MAX_PAYLOAD);
            end
        end else begin
            len_eff = len_reg;
        end
    end

    assign count_inc = bytes_seen_reg + LEN_W'(1);
    assign last      = (count_inc >= len_eff);

    // Frame position update on each accepted transaction.
    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        len_next        = len_reg;
        if (q_push) begin
            bytes_seen_next = last ? '0 : count_inc;
            len_next        = len_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bytes_seen_reg <= '0;
            len_reg        <= '0;
        end else begin
            bytes_seen_reg <= bytes_seen_next;
            len_reg        <= len_next;
        end
    end

    // Entry handed to the queue.
    always_comb
    begin
        q_entry.first      = first;
        q_entry.last       = last;
        q_entry.len_byte   = {{(DATA_W-LEN_W){1'b0}}, len_eff} + DATA_W'(1);
        q_entry.frame_type = in_item.frame_type;
        q_entry.data_byte  = in_item.data_byte;
    end

endmodule

>>> rtl/core/crc8fe_queue.sv
// ----------------------------------------------------------------------------
// CRC-8 frame encoder entry queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc8fe_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_push,
    input  crc8fe_pkg::entry_t wr_entry,
    input  logic               rd_pop,
    output crc8fe_pkg::entry_t rd_entry,
    output logic               q_full,
    output logic               q_empty
);
    import crc8fe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full   = (count_reg == CNT_W'(DEPTH));
    assign q_empty  = (count_reg == '0);
    assign do_wr    = wr_push && !q_full;
    assign do_rd    = rd_pop && !q_empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

>>> rtl/core/crc8fe_back.sv
// ----------------------------------------------------------------------------
// CRC-8 frame encoder back end
// Sequences headers, LEN, TYPE, payload and CRC bytes, one byte per cycle while the output slot is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc8fe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            header_first,
    input  logic [7:0]            header_second,
    input  crc8fe_pkg::entry_t    q_entry,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic                  out_pop,
    output logic                  out_valid,
    output crc8fe_pkg::out_item_t out_item
);
    import crc8fe_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HDR2 = 6'b000010,
        S_LEN  = 6'b000100,
        S_TYPE = 6'b001000,
        S_DATA = 6'b010000,
        S_CRC  = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [DATA_W-1:0] crc_reg;
    logic [DATA_W-1:0] crc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;
    logic              out_ready;

    assign out_ready = !out_valid_reg || out_pop;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Byte sequencer: one output byte per cycle whenever the output slot frees and, in idle, an entry waits.
    always_comb
    begin
        state_next     = state_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !out_pop;
        out_next       = out_reg;
        q_pop          = 1'b0;
        if (out_ready) begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty) begin
                        out_valid_next = 1'b1;
                        if (q_entry.first) begin
                            out_next   = '{out_byte: header_first, frame_end: 1'b0};
                            state_next = S_HDR2;
                        end else begin
                            out_next   = '{out_byte: q_entry.data_byte, frame_end: 1'b0};
                            crc_next   = crc_feed(crc_reg, q_entry.data_byte);
                            q_pop      = 1'b1;
                            state_next = q_entry.last ? S_CRC : S_IDLE;
                        end
                    end
                end
                S_HDR2:
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: header_second, frame_end: 1'b0};
                    state_next     = S_LEN;
                end
                S_LEN:
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: q_entry.len_byte, frame_end: 1'b0};
                    crc_next       = crc_feed(CRC_INIT, q_entry.len_byte);
                    state_next     = S_TYPE;
                end
                S_TYPE:
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: q_entry.frame_type, frame_end: 1'b0};
                    crc_next       = crc_feed(crc_reg, q_entry.frame_type);
                    state_next     = S_DATA;
                end
                S_DATA:
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: q_entry.data_byte, frame_end: 1'b0};
                    crc_next       = crc_feed(crc_reg, q_entry.data_byte);
                    q_pop          = 1'b1;
                    state_next     = q_entry.last ? S_CRC : S_IDLE;
                end
                S_CRC:
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: crc_reg, frame_end: 1'b1};
                    crc_next       = CRC_INIT;
                    state_next     = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register needs no reset.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

>>> rtl/core/crc8_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// CRC-8 frame encoder top level
// Builds serial frames with two sync bytes, LEN, TYPE, payload and a CRC-8.
// ----------------------------------------------------------------------------
// Each payload byte pushed in becomes one queue entry; the back end then
// sends one frame byte per cycle, while the output is taken, through a
// single output register. A payload byte in the middle of a frame yields
// only its data byte, the first byte of a frame also yields the two sync
// bytes, LEN and TYPE before its data, and the last byte is followed by the
// CRC. A queue of QUEUE_DEPTH entries lets push continue while the result
// side stalls, until it fills. Header registers should be written only
// between frames; lengths of 0 are treated as 1 and lengths above
// MAX_PAYLOAD are clamped.
`timescale 1ns / 1ps

module crc8_frame_encoder_top #(
    parameter int MAX_PAYLOAD = 27,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  crc8fe_pkg::in_item_t                in_item,
    output logic                                empty,
    input  logic                                pop,
    output crc8fe_pkg::out_item_t               out_item,
    input  logic                                wr_en,
    input  logic [crc8fe_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [crc8fe_pkg::DATA_W-1:0]       wr_data
);
    import crc8fe_pkg::*;

    logic [DATA_W-1:0] header_first_reg;
    logic [DATA_W-1:0] header_first_next;
    logic [DATA_W-1:0] header_second_reg;
    logic [DATA_W-1:0] header_second_next;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    entry_t            wr_entry;
    entry_t            rd_entry;
    logic              out_valid;

    // Configuration register writes.
    always_comb
    begin
        header_first_next  = header_first_reg;
        header_second_next = header_second_reg;
        if (wr_en) begin
            case (wr_index)
                REG_HEADER_FIRST:  header_first_next  = wr_data;
                REG_HEADER_SECOND: header_second_next = wr_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
        end else begin
            header_first_reg  <= header_first_next;
            header_second_reg <= header_second_next;
        end
    end

    assign full  = q_full;
    assign empty = !out_valid;

    // Front end: frame tracking and byte classification.
    crc8fe_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .in_item(in_item),
        .q_full (q_full),
        .q_push (q_push),
        .q_entry(wr_entry)
    );

    // Decoupling queue.
    crc8fe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_push (q_push),
        .wr_entry(wr_entry),
        .rd_pop  (q_pop),
        .rd_entry(rd_entry),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // Back end: byte sequencer and CRC.
    crc8fe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .header_first (header_first_reg),
        .header_second(header_second_reg),
        .q_entry      (rd_entry),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_pop      (pop && out_valid),
        .out_valid    (out_valid),
        .out_item     (out_item)
    );

endmodule

>>> rtl/core/crc8fe_checker.sv
// ----------------------------------------------------------------------------
// CRC-8 frame encoder port checker
// Port-level properties of the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc8_frame_encoder_top_defines.svh"

module crc8fe_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input crc8fe_pkg::out_item_t out_item
);
    import crc8fe_pkg::*;

    // A waiting result that is not taken stays put.
    `CRC8FE_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_item), "result changed while stalled")

    // An accepted transaction must be followed by a result, once it has passed the queue and the output register.
    `CRC8FE_ASSERT_NOW(a_push_latency, push && !full, ##2 !empty, "no result after accepted transaction")

    // A full queue implies the back end keeps a result on the output.
    `CRC8FE_ASSERT_NEXT(a_full_drains, full, !empty, "output idle while queue is full")

endmodule

bind crc8_frame_encoder_top crc8fe_checker u_checker (.*);
